// File: rtl/sst_pkg.sv
`default_nettype none

package sst_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  localparam int S_FRAC = 16;
  localparam int S_W    = S_FRAC + 1;
  localparam int T_W    = S_FRAC + 2;
  localparam int H_W    = S_FRAC + 1;
  localparam int S_HALF = 1 << (S_FRAC - 1);
  localparam int T_THREE = 3 << S_FRAC;

  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_X_LOW  = 2'd0;
  localparam cfg_idx_t CFG_X_HIGH = 2'd1;
  localparam cfg_idx_t CFG_Y_LOW  = 2'd2;
  localparam cfg_idx_t CFG_Y_HIGH = 2'd3;

  typedef logic [1:0] sel_t;
  localparam sel_t SEL_LOW  = 2'd0;
  localparam sel_t SEL_HIGH = 2'd1;
  localparam sel_t SEL_MID  = 2'd2;

  typedef struct packed {
    logic valid;
    sel_t sel;
  } ctl_t;

endpackage

`default_nettype wire

// File: rtl/sst_front.sv
`default_nettype none

module sst_front #(
  parameter int DATA_WIDTH = sst_pkg::DATA_WIDTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire  signed [DATA_WIDTH-1:0] x_low,
  input  wire  signed [DATA_WIDTH-1:0] x_high,
  input  wire                          valid_i,
  input  wire  signed [DATA_WIDTH-1:0] act_i,
  output logic                         ready_o,
  output sst_pkg::ctl_t                ctl_o,
  output logic        [DATA_WIDTH-1:0] num_o,
  input  wire                          ready_i
);

  sst_pkg::ctl_t         ctl_r;
  sst_pkg::ctl_t         ctl_nxt;
  logic [DATA_WIDTH-1:0] num_r;
  logic [DATA_WIDTH-1:0] num_nxt;

  always_comb begin
    ctl_nxt.valid = valid_i;
    if (act_i > x_high) begin
      ctl_nxt.sel = sst_pkg::SEL_HIGH;
    end else if (act_i > x_low) begin
      ctl_nxt.sel = sst_pkg::SEL_MID;
    end else begin
      ctl_nxt.sel = sst_pkg::SEL_LOW;
    end
    num_nxt = DATA_WIDTH'(act_i - x_low);
  end

  assign ready_o = ~ctl_r.valid | ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (ready_o) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o) begin
      num_r <= num_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign num_o = num_r;

endmodule

`default_nettype wire

// File: rtl/sst_div.sv
`default_nettype none

module sst_div #(
  parameter int DATA_WIDTH = sst_pkg::DATA_WIDTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire  [DATA_WIDTH-1:0]        den,
  input  sst_pkg::ctl_t                ctl_i,
  input  wire  [DATA_WIDTH-1:0]        num_i,
  output logic                         ready_o,
  output sst_pkg::ctl_t                ctl_o,
  output logic [sst_pkg::S_W-1:0]      quo_o,
  input  wire                          ready_i
);

  localparam int NSTG = sst_pkg::S_W;

  sst_pkg::ctl_t          ctl_r [NSTG];
  logic [sst_pkg::S_W-1:0] quo_r [NSTG];
  logic [DATA_WIDTH-1:0]  rem_r [NSTG-1];
  logic [NSTG:0]          stg_rdy;

  assign stg_rdy[NSTG] = ready_i;

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    sst_pkg::ctl_t           ctl_prev;
    logic [sst_pkg::S_W-1:0] quo_prev;
    logic [DATA_WIDTH:0]     trial;
    logic                    ge;
    logic [DATA_WIDTH-1:0]   rem_nxt;
    logic [sst_pkg::S_W-1:0] quo_nxt;

    if (k == 0) begin : g_first
      always_comb begin
        ctl_prev = ctl_i;
        quo_prev = '0;
        trial    = {1'b0, num_i};
      end
    end else begin : g_next
      always_comb begin
        ctl_prev = ctl_r[k-1];
        quo_prev = quo_r[k-1];
        trial    = {rem_r[k-1], 1'b0};
      end
    end

    always_comb begin
      ge      = trial >= {1'b0, den};
      rem_nxt = ge ? DATA_WIDTH'(trial - {1'b0, den}) : DATA_WIDTH'(trial);
      quo_nxt = {quo_prev[sst_pkg::S_W-2:0], ge};
    end

    assign stg_rdy[k] = ~ctl_r[k].valid | stg_rdy[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k] <= '0;
      end else if (stg_rdy[k]) begin
        ctl_r[k] <= ctl_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (stg_rdy[k]) begin
        quo_r[k] <= quo_nxt;
      end
    end

    if (k < NSTG - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (stg_rdy[k]) begin
          rem_r[k] <= rem_nxt;
        end
      end
    end
  end

  assign ready_o = stg_rdy[0];
  assign ctl_o   = ctl_r[NSTG-1];
  assign quo_o   = quo_r[NSTG-1];

endmodule

`default_nettype wire

// File: rtl/sst_poly.sv
`default_nettype none

module sst_poly (
  input  wire                        clk,
  input  wire                        rst_n,
  input  sst_pkg::ctl_t              ctl_i,
  input  wire  [sst_pkg::S_W-1:0]    s_i,
  output logic                       ready_o,
  output sst_pkg::ctl_t              ctl_o,
  output logic [sst_pkg::H_W-1:0]    h_o,
  input  wire                        ready_i
);

  localparam int SQ_W = 2 * sst_pkg::S_W;
  localparam int P_W  = sst_pkg::S_W + sst_pkg::T_W;

  sst_pkg::ctl_t           ctl_a_r;
  sst_pkg::ctl_t           ctl_b_r;
  logic [sst_pkg::S_W-1:0] s2_r;
  logic [sst_pkg::S_W-1:0] s2_nxt;
  logic [sst_pkg::T_W-1:0] t_r;
  logic [sst_pkg::T_W-1:0] t_nxt;
  logic [sst_pkg::H_W-1:0] h_r;
  logic [sst_pkg::H_W-1:0] h_nxt;
  logic [SQ_W-1:0]         sq;
  logic [SQ_W-1:0]         sq_rnd;
  logic [P_W-1:0]          prod;
  logic [P_W-1:0]          prod_rnd;
  logic                    rdy_a;
  logic                    rdy_b;

  always_comb begin
    sq     = SQ_W'(s_i) * SQ_W'(s_i);
    sq_rnd = sq + SQ_W'(sst_pkg::S_HALF);
    s2_nxt = sst_pkg::S_W'(sq_rnd >> sst_pkg::S_FRAC);
    t_nxt  = sst_pkg::T_W'(sst_pkg::T_THREE) - {s_i, 1'b0};
  end

  always_comb begin
    prod     = P_W'(s2_r) * P_W'(t_r);
    prod_rnd = prod + P_W'(sst_pkg::S_HALF);
    h_nxt    = sst_pkg::H_W'(prod_rnd >> sst_pkg::S_FRAC);
  end

  assign rdy_b   = ~ctl_b_r.valid | ready_i;
  assign rdy_a   = ~ctl_a_r.valid | rdy_b;
  assign ready_o = rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
    end else begin
      if (rdy_a) begin
        ctl_a_r <= ctl_i;
      end
      if (rdy_b) begin
        ctl_b_r <= ctl_a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      s2_r <= s2_nxt;
      t_r  <= t_nxt;
    end
    if (rdy_b) begin
      h_r <= h_nxt;
    end
  end

  assign ctl_o = ctl_b_r;
  assign h_o   = h_r;

endmodule

`default_nettype wire

// File: rtl/sst_scale.sv
`default_nettype none

module sst_scale #(
  parameter int DATA_WIDTH = sst_pkg::DATA_WIDTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire  signed [DATA_WIDTH:0]   dy,
  input  wire         [DATA_WIDTH-1:0] y_low,
  input  wire         [DATA_WIDTH-1:0] y_high,
  input  sst_pkg::ctl_t                ctl_i,
  input  wire  [sst_pkg::H_W-1:0]      h_i,
  output logic                         ready_o,
  output logic                         out_valid,
  output logic        [DATA_WIDTH-1:0] out_response,
  input  wire                          out_stall
);

  localparam int PW = DATA_WIDTH + sst_pkg::H_W + 2;

  sst_pkg::ctl_t         ctl_c_r;
  logic signed [PW-1:0]  prod_r;
  logic signed [PW-1:0]  prod_nxt;
  logic signed [PW-1:0]  shifted;
  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] resp_r;
  logic [DATA_WIDTH-1:0] resp_nxt;
  logic                  rdy_c;
  logic                  rdy_d;

  always_comb begin
    prod_nxt = $signed(dy) * $signed({1'b0, h_i});
    prod_nxt = prod_nxt + PW'(sst_pkg::S_HALF);
  end

  always_comb begin
    shifted = prod_r >>> sst_pkg::S_FRAC;
    unique case (ctl_c_r.sel)
      sst_pkg::SEL_HIGH: resp_nxt = y_high;
      sst_pkg::SEL_MID:  resp_nxt = y_low + shifted[DATA_WIDTH-1:0];
      default:           resp_nxt = y_low;
    endcase
  end

  assign rdy_d   = ~out_valid_r | ~out_stall;
  assign rdy_c   = ~ctl_c_r.valid | rdy_d;
  assign ready_o = rdy_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_c_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy_c) begin
        ctl_c_r <= ctl_i;
      end
      if (rdy_d) begin
        out_valid_r <= ctl_c_r.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      prod_r <= prod_nxt;
    end
    if (rdy_d) begin
      resp_r <= resp_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_response = resp_r;

endmodule

`default_nettype wire

// File: rtl/smoothstep_threshold_top.sv
// Clamped smoothstep threshold on a stream of signed fixed-point activations.
// Input channel: in_valid / in_stall with in_activation; a transaction happens
// on a rising edge with in_valid high and in_stall low. Each input transaction
// yields exactly one out_response transaction, in order, on out_valid /
// out_stall under the same rule.
// The pipeline holds one compare stage, a 17-stage restoring divider that forms
// one quotient bit per stage, two multiply stages for the cubic and two for the
// output scaling.
// Throughput is one transaction per cycle while out_stall is low; every stage is fully pipelined.
// The cfg port writes one of x_low, x_high, y_low, y_high (index 0..3) per cfg_we;
// write it only while no transaction is in flight.
// Reset (rst_n low, synchronous) empties the pipeline and loads the unit form:
// thresholds 0 and 1.0, levels 0 and 1.0.
// While out_stall is high a valid output holds; earlier stages keep filling any
// empty slots, and in_stall rises once the pipeline is full.
`default_nettype none

module smoothstep_threshold_top #(
  parameter int DATA_WIDTH = sst_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = sst_pkg::FRAC_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire  signed [DATA_WIDTH-1:0]    in_activation,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic signed [DATA_WIDTH-1:0]    out_response,
  input  wire                             cfg_we,
  input  wire  [sst_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [DATA_WIDTH-1:0]           cfg_wdata
);

  localparam logic [DATA_WIDTH-1:0] ONE_C = {{(DATA_WIDTH-1){1'b0}}, 1'b1} << FRAC_BITS;

  logic signed [DATA_WIDTH-1:0] x_low_r;
  logic signed [DATA_WIDTH-1:0] x_high_r;
  logic signed [DATA_WIDTH-1:0] y_low_r;
  logic signed [DATA_WIDTH-1:0] y_high_r;
  logic        [DATA_WIDTH-1:0] den_r;
  logic signed [DATA_WIDTH:0]   dy_r;

  sst_pkg::ctl_t           front_ctl;
  logic [DATA_WIDTH-1:0]   front_num;
  logic                    front_rdy;
  sst_pkg::ctl_t           div_ctl;
  logic [sst_pkg::S_W-1:0] div_quo;
  logic                    div_rdy;
  sst_pkg::ctl_t           poly_ctl;
  logic [sst_pkg::H_W-1:0] poly_h;
  logic                    poly_rdy;
  logic                    scale_rdy;
  logic [DATA_WIDTH-1:0]   resp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_low_r  <= '0;
      x_high_r <= ONE_C;
      y_low_r  <= '0;
      y_high_r <= ONE_C;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sst_pkg::CFG_X_LOW:  x_low_r  <= cfg_wdata;
        sst_pkg::CFG_X_HIGH: x_high_r <= cfg_wdata;
        sst_pkg::CFG_Y_LOW:  y_low_r  <= cfg_wdata;
        sst_pkg::CFG_Y_HIGH: y_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    den_r <= DATA_WIDTH'(x_high_r - x_low_r);
    dy_r  <= (DATA_WIDTH+1)'(y_high_r) - (DATA_WIDTH+1)'(y_low_r);
  end

  sst_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .x_low  (x_low_r),
    .x_high (x_high_r),
    .valid_i(in_valid),
    .act_i  (in_activation),
    .ready_o(front_rdy),
    .ctl_o  (front_ctl),
    .num_o  (front_num),
    .ready_i(div_rdy)
  );

  sst_div #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .den    (den_r),
    .ctl_i  (front_ctl),
    .num_i  (front_num),
    .ready_o(div_rdy),
    .ctl_o  (div_ctl),
    .quo_o  (div_quo),
    .ready_i(poly_rdy)
  );

  sst_poly u_poly (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (div_ctl),
    .s_i    (div_quo),
    .ready_o(poly_rdy),
    .ctl_o  (poly_ctl),
    .h_o    (poly_h),
    .ready_i(scale_rdy)
  );

  sst_scale #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .dy          (dy_r),
    .y_low       (y_low_r),
    .y_high      (y_high_r),
    .ctl_i       (poly_ctl),
    .h_i         (poly_h),
    .ready_o     (scale_rdy),
    .out_valid   (out_valid),
    .out_response(resp),
    .out_stall   (out_stall)
  );

  assign in_stall     = ~front_rdy;
  assign out_response = resp;

endmodule

`default_nettype wire

// File: verif/smoothstep_threshold_checker.sv
`timescale 1ns / 1ps

module smoothstep_threshold_checker #(
  parameter int DATA_WIDTH = sst_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = sst_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_activation,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic signed [DATA_WIDTH-1:0] out_response,
  input  logic                         cfg_we,
  input  sst_pkg::cfg_idx_t            cfg_index,
  input  logic [DATA_WIDTH-1:0]        cfg_wdata,
  output int                           fail_count,
  output int                           pending
);

  typedef logic signed [DATA_WIDTH-1:0] level_t;

  localparam level_t UNIT = level_t'(1 << FRAC_BITS);

  level_t x_low, x_high, y_low, y_high;
  level_t expected_responses[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic level_t smoothstep_predict(level_t act);
    longint a, xl, xh, yl, yh, s, s2, t, h, r;
    a  = act;
    xl = x_low;
    xh = x_high;
    yl = y_low;
    yh = y_high;
    if (a > xh) begin
      r = yh;
    end else if (a > xl) begin
      s  = ((a - xl) << sst_pkg::S_FRAC) / (xh - xl);
      s2 = (s * s + sst_pkg::S_HALF) >>> sst_pkg::S_FRAC;
      t  = sst_pkg::T_THREE - 2 * s;
      h  = (s2 * t + sst_pkg::S_HALF) >>> sst_pkg::S_FRAC;
      r  = yl + (((yh - yl) * h + sst_pkg::S_HALF) >>> sst_pkg::S_FRAC);
    end else begin
      r = yl;
    end
    return level_t'(r);
  endfunction

  task automatic note_failure(string msg);
    if (fail_count < 10) begin
      $display("%0t: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin
    level_t want;
    if (!rst_n) begin
      x_low  = '0;
      x_high = UNIT;
      y_low  = '0;
      y_high = UNIT;
      expected_responses.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_responses.size() == 0) begin
          note_failure($sformatf("unexpected response %0d", out_response));
        end else begin
          want = expected_responses.pop_front();
          if (out_response !== want) begin
            note_failure($sformatf("response mismatch: expected %0d, got %0d",
                                   want, out_response));
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_responses.push_back(smoothstep_predict(in_activation));
      end
      if (cfg_we) begin
        case (cfg_index)
          sst_pkg::CFG_X_LOW:  x_low  = level_t'(cfg_wdata);
          sst_pkg::CFG_X_HIGH: x_high = level_t'(cfg_wdata);
          sst_pkg::CFG_Y_LOW:  y_low  = level_t'(cfg_wdata);
          sst_pkg::CFG_Y_HIGH: y_high = level_t'(cfg_wdata);
          default: ;
        endcase
      end
    end
    pending = expected_responses.size();
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int DW          = sst_pkg::DATA_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic signed [DW-1:0] level_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  level_t            in_activation = '0;
  logic              out_stall = 1'b0;
  logic              cfg_we = 1'b0;
  sst_pkg::cfg_idx_t cfg_index = sst_pkg::CFG_X_LOW;
  logic [DW-1:0]     cfg_wdata = '0;

  wire           in_stall;
  wire           out_valid;
  wire [DW-1:0]  out_response;

  int fail_count;
  int pending;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int x_lo = 0;
  int x_hi = 256;

  smoothstep_threshold_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_activation (in_activation),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_response  (out_response),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  smoothstep_threshold_checker response_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_activation (in_activation),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_response  (out_response),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send(level_t v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_activation <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // hold off until every transaction in flight has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic apply_thresholds(int xl, int xh, int yl, int yh);
    int                vals[4];
    sst_pkg::cfg_idx_t regs[4];
    int                i;
    vals = '{xl, xh, yl, yh};
    regs = '{sst_pkg::CFG_X_LOW, sst_pkg::CFG_X_HIGH, sst_pkg::CFG_Y_LOW,
             sst_pkg::CFG_Y_HIGH};
    for (i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= level_t'(vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    x_lo = xl;
    x_hi = xh;
  endtask

  function automatic int rand_level();
    return int'(level_t'($urandom));
  endfunction

  task automatic choose_thresholds();
    int mode, xl, xh, yl, yh;
    mode = $urandom_range(0, 7);
    yl = rand_level();
    yh = rand_level();
    if (mode == 0) begin
      xl = rand_level();
      xh = rand_level();
    end else if (mode <= 4) begin
      xl = int'($urandom_range(0, 64768)) - 32768;
      xh = xl + int'($urandom_range(1, 767));
    end else if (mode == 5) begin
      xl = -32768;
      xh = 32767;
      yl = $urandom_range(0, 1) ? -32768 : 32767;
      yh = -yl - 1;
    end else if (mode == 6) begin
      xl = int'($urandom_range(0, 65534)) - 32768;
      xh = xl + 1;
    end else begin
      xl = rand_level();
      xh = xl;
    end
    apply_thresholds(xl, xh, yl, yh);
  endtask

  function automatic level_t pick_activation();
    int lo, hi;
    if ($urandom_range(0, 1)) return level_t'($urandom);
    lo = ((x_lo < x_hi) ? x_lo : x_hi) - 4;
    hi = ((x_lo < x_hi) ? x_hi : x_lo) + 4;
    if (lo < -32768) lo = -32768;
    if (hi > 32767) hi = 32767;
    return level_t'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  initial begin
    int send_pct[3];
    int recv_pct[3];
    int phase;
    send_pct = '{35, 84, 0};
    recv_pct = '{84, 35, 0};

    send_idle_pct  = send_pct[0];
    recv_stall_pct = recv_pct[0];
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // unit form from reset
    send(-32768);
    send(32767);
    send(0);
    send(1);
    send(128);
    send(255);
    send(256);
    send(257);
    send(-1);
    send(level_t'(16'h5555));
    send(level_t'(16'haaaa));

    // widest span and widest swing
    drain();
    apply_thresholds(-32768, 32767, -32768, 32767);
    send(-32768);
    send(-32767);
    send(0);
    send(32767);

    // thresholds out of order
    drain();
    apply_thresholds(200, -100, 1000, -1000);
    send(200);
    send(201);
    send(-100);
    send(0);
    send(-101);

    // equal thresholds, falling levels
    drain();
    apply_thresholds(64, 64, 32767, -32768);
    send(64);
    send(65);

    // falling levels across the middle
    drain();
    apply_thresholds(-10, 300, 500, -700);
    send(100);
    send(-9);
    send(300);

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct  = send_pct[phase];
      recv_stall_pct = recv_pct[phase];
      repeat (6) begin
        drain();
        choose_thresholds();
        repeat (28) send(pick_activation());
      end
    end

    drain();
    repeat (30) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/sst_pkg.sv
rtl/sst_front.sv
rtl/sst_div.sv
rtl/sst_poly.sv
rtl/sst_scale.sv
rtl/smoothstep_threshold_top.sv
verif/smoothstep_threshold_checker.sv
verif/testbench.sv
